### src/bpy_pkg.sv
// ============================================================================
// bpy_pkg
// Shared types and constants for the BMP pixel to YCbCr converter.
// ============================================================================
`default_nettype none

package bpy_pkg;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int DIM_W    = 13;   // width and height registers
    localparam int POS_W    = 12;   // row and column fields
    localparam int BPOS_W   = 14;   // byte position within a row
    localparam int CFG_IDX_W = 2;
    localparam int ACC_W    = 26;   // colour sum, 16 fraction bits

    // Hardware ceiling on either image dimension
    localparam int DIM_CEIL = 4096;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_TOP_DOWN     = 2'd2
    } cfg_index_t;

    // Position of a byte within its blue, green, red triplet
    typedef enum logic [1:0] {
        LANE_BLUE  = 2'd0,
        LANE_GREEN = 2'd1,
        LANE_RED   = 2'd2
    } lane_t;

    // BT.601 full-range coefficients, scaled by 65536
    localparam logic [16:0] C_Y_R  = 17'd19595;
    localparam logic [16:0] C_Y_G  = 17'd38470;
    localparam logic [16:0] C_Y_B  = 17'd7471;
    localparam logic [16:0] C_CB_R = 17'd11058;   // subtracted
    localparam logic [16:0] C_CB_G = 17'd21710;   // subtracted
    localparam logic [16:0] C_CB_B = 17'd32768;
    localparam logic [16:0] C_CR_R = 17'd32768;
    localparam logic [16:0] C_CR_G = 17'd27439;   // subtracted
    localparam logic [16:0] C_CR_B = 17'd5329;    // subtracted

    // Rounding half and the chroma offset of 128 with rounding
    localparam logic [ACC_W-1:0] ROUND_HALF  = 26'd32768;
    localparam logic [ACC_W-1:0] CHROMA_BIAS = 26'd8421376;

    // Result payload
    typedef struct packed {
        logic [BYTE_W-1:0] luma;
        logic [BYTE_W-1:0] chroma_blue;
        logic [BYTE_W-1:0] chroma_red;
        logic [POS_W-1:0]  out_row;
        logic [POS_W-1:0]  out_column;
        logic              last_pixel;
    } ycc_beat_t;

endpackage

`default_nettype wire

### src/bpy_byte_if.sv
// ============================================================================
// bpy_byte_if
// Input channel: one byte of BMP pixel data per beat.
// ============================================================================
`default_nettype none

interface bpy_byte_if
    import bpy_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

### src/bpy_ycc_if.sv
// ============================================================================
// bpy_ycc_if
// Output channel: one YCbCr pixel with its position per beat.
// ============================================================================
`default_nettype none

interface bpy_ycc_if
    import bpy_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] luma;
    logic [BYTE_W-1:0] chroma_blue;
    logic [BYTE_W-1:0] chroma_red;
    logic [POS_W-1:0]  out_row;
    logic [POS_W-1:0]  out_column;
    logic              last_pixel;

    modport source (output valid, output luma, output chroma_blue, output chroma_red,
                    output out_row, output out_column, output last_pixel, input ready);
    modport sink   (input valid, input luma, input chroma_blue, input chroma_red,
                    input out_row, input out_column, input last_pixel, output ready);
endinterface

`default_nettype wire

### src/bpy_cfg_if.sv
// ============================================================================
// bpy_cfg_if
// Configuration write channel: register index and write data per beat.
// ============================================================================
`default_nettype none

interface bpy_cfg_if
    import bpy_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/bmp_pixel_to_ycbcr_core.sv
// ============================================================================
// bmp_pixel_to_ycbcr_core
// Streams BMP pixel bytes (B, G, R, row padding) and emits BT.601 full-range
// YCbCr pixels with output row, column and a last-pixel mark.
// ============================================================================
//
//  channel   direction  payload                                   handshake
//  pix_in    in         data_byte[7:0]                            valid/ready
//  ycc_out   out        luma, chroma_blue, chroma_red, out_row,   valid/ready
//                       out_column, last_pixel
//  cfg       in         index[1:0], data[12:0]                    valid/ready
//
//  One byte is taken per cycle unless stage A is held by a stalled ycc_out. A red
//  byte passes through stage A (byte position and row counters plus capture) and
//  then stage B (the constant multiply, sum and clamp into the output register).
//  Stage A empties into the output register whenever that is free or taken,
//  so a byte is still accepted while one finished pixel waits downstream.
//  cfg.ready is always high; registers take effect on the next byte.
//  Reset clears the counters and returns width 1, height 1, bottom-up.
// ============================================================================
`default_nettype none

module bmp_pixel_to_ycbcr_core
    import bpy_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  wire          clk,
    input  wire          rst_n,
    bpy_byte_if.sink     pix_in,
    bpy_ycc_if.source    ycc_out,
    bpy_cfg_if.sink      cfg
);

    // Effective ceilings on width and height
    localparam int W_LIM_I = (MAX_WIDTH  < DIM_CEIL) ? ((MAX_WIDTH  < 1) ? 1 : MAX_WIDTH)
                                                     : DIM_CEIL;
    localparam int H_LIM_I = (MAX_HEIGHT < DIM_CEIL) ? ((MAX_HEIGHT < 1) ? 1 : MAX_HEIGHT)
                                                     : DIM_CEIL;
    localparam logic [DIM_W-1:0] W_LIM = DIM_W'(W_LIM_I);
    localparam logic [DIM_W-1:0] H_LIM = DIM_W'(H_LIM_I);
    localparam logic [BPOS_W-1:0] STRIDE_MAX = BPOS_W'(((W_LIM_I * 3) + 3) / 4 * 4);

    // Configuration registers
    logic [DIM_W-1:0] image_width_reg;
    logic [DIM_W-1:0] image_height_reg;
    logic             top_down_reg;

    // Row assembly state
    logic [BPOS_W-1:0] byte_in_row_reg, byte_in_row_next;
    lane_t             lane_reg, lane_next;
    logic [POS_W-1:0]  col_reg, col_next;
    logic [POS_W-1:0]  file_row_reg, file_row_next;
    logic [BYTE_W-1:0] held_blue_reg, held_blue_next;
    logic [BYTE_W-1:0] held_green_reg, held_green_next;

    // Stage A: captured pixel waiting for conversion
    logic              a_valid_reg, a_valid_next;
    logic [BYTE_W-1:0] a_blue_reg, a_green_reg, a_red_reg;
    logic [POS_W-1:0]  a_row_reg, a_col_reg;
    logic              a_last_reg;

    // Stage B: output register
    logic              b_valid_reg, b_valid_next;
    ycc_beat_t         b_beat_reg, b_beat_next;

    // Derived geometry and control
    logic [DIM_W-1:0]  w_eff, h_eff;
    logic [BPOS_W-1:0] data_bytes, stride;
    logic [BPOS_W:0]   pos_inc;
    logic              row_end, in_pixel, emit, in_fire, a_adv;
    logic [DIM_W-1:0]  row_inc;
    logic [POS_W-1:0]  row_out;
    logic              last_out;

    // Conversion datapath
    logic [ACC_W-1:0]  y_acc, cb_acc, cr_acc;

    function automatic logic [ACC_W-1:0] scale(input logic [BYTE_W-1:0] v,
                                               input logic [16:0] c);
        scale = ACC_W'(v) * ACC_W'(c);
    endfunction

    function automatic logic [BYTE_W-1:0] to_byte(input logic [ACC_W-1:0] acc);
        logic [ACC_W-17:0] whole;
        whole = acc[ACC_W-1:16];
        if (whole > (ACC_W-16)'(255))
        begin
            to_byte = 8'hFF;
        end
        else
        begin
            to_byte = whole[BYTE_W-1:0];
        end
    endfunction

    // Configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= DIM_W'(1);
            image_height_reg <= DIM_W'(1);
            top_down_reg     <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg.data;
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg.data;
                CFG_TOP_DOWN:     top_down_reg     <= cfg.data[0];
                default:          ;
            endcase
        end
    end

    // Clamp dimensions, a zero register acts as one
    always_comb
    begin
        if (image_width_reg == '0)
            w_eff = DIM_W'(1);
        else if (image_width_reg > W_LIM)
            w_eff = W_LIM;
        else
            w_eff = image_width_reg;

        if (image_height_reg == '0)
            h_eff = DIM_W'(1);
        else if (image_height_reg > H_LIM)
            h_eff = H_LIM;
        else
            h_eff = image_height_reg;
    end

    // Row geometry: pixel bytes and stride padded to four
    assign data_bytes = {1'b0, w_eff} + {w_eff, 1'b0};
    assign stride     = (data_bytes + BPOS_W'(3)) & ~BPOS_W'(3);
    assign pos_inc    = {1'b0, byte_in_row_reg} + (BPOS_W+1)'(1);
    assign row_end    = pos_inc >= {1'b0, stride};
    assign in_pixel   = byte_in_row_reg < data_bytes;
    assign emit       = in_pixel && (lane_reg == LANE_RED);
    assign row_inc    = {1'b0, file_row_reg} + DIM_W'(1);

    // Handshake: stage A drains when the output register is free or taken
    assign a_adv        = a_valid_reg && (!b_valid_reg || ycc_out.ready);
    assign pix_in.ready = !a_valid_reg || a_adv;
    assign in_fire      = pix_in.valid && pix_in.ready;

    // Output row and last mark for the pixel completed by this beat
    assign row_out  = top_down_reg ? file_row_reg
                                   : POS_W'(h_eff - DIM_W'(1) - {1'b0, file_row_reg});
    assign last_out = (row_inc >= h_eff) && (({1'b0, col_reg} + DIM_W'(1)) == w_eff);

    // Counter and held-byte next state
    always_comb
    begin
        byte_in_row_next = byte_in_row_reg;
        lane_next        = lane_reg;
        col_next         = col_reg;
        file_row_next    = file_row_reg;
        held_blue_next   = held_blue_reg;
        held_green_next  = held_green_reg;
        a_valid_next     = a_adv ? 1'b0 : a_valid_reg;

        if (in_fire)
        begin
            if (in_pixel && lane_reg == LANE_BLUE)
                held_blue_next = pix_in.data_byte;
            if (in_pixel && lane_reg == LANE_GREEN)
                held_green_next = pix_in.data_byte;
            if (emit)
                a_valid_next = 1'b1;

            if (row_end)
            begin
                byte_in_row_next = '0;
                lane_next        = LANE_BLUE;
                col_next         = '0;
                file_row_next    = (row_inc >= h_eff) ? '0 : row_inc[POS_W-1:0];
            end
            else
            begin
                byte_in_row_next = pos_inc[BPOS_W-1:0];
                unique case (lane_reg)
                    LANE_BLUE:  lane_next = LANE_GREEN;
                    LANE_GREEN: lane_next = LANE_RED;
                    LANE_RED:
                    begin
                        lane_next = LANE_BLUE;
                        col_next  = col_reg + POS_W'(1);
                    end
                    default:    lane_next = LANE_BLUE;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_in_row_reg <= '0;
            lane_reg        <= LANE_BLUE;
            col_reg         <= '0;
            file_row_reg    <= '0;
            held_blue_reg   <= '0;
            held_green_reg  <= '0;
            a_valid_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
        end
        else
        begin
            byte_in_row_reg <= byte_in_row_next;
            lane_reg        <= lane_next;
            col_reg         <= col_next;
            file_row_reg    <= file_row_next;
            held_blue_reg   <= held_blue_next;
            held_green_reg  <= held_green_next;
            a_valid_reg     <= a_valid_next;
            b_valid_reg     <= b_valid_next;
        end
    end

    // Stage A payload capture
    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            a_blue_reg  <= held_blue_reg;
            a_green_reg <= held_green_reg;
            a_red_reg   <= pix_in.data_byte;
            a_row_reg   <= row_out;
            a_col_reg   <= col_reg;
            a_last_reg  <= last_out;
        end
    end

    // Stage B: constant multiplies, sums stay non-negative by construction
    assign y_acc  = scale(a_red_reg, C_Y_R) + scale(a_green_reg, C_Y_G)
                  + scale(a_blue_reg, C_Y_B) + ROUND_HALF;
    assign cb_acc = scale(a_blue_reg, C_CB_B) + CHROMA_BIAS
                  - scale(a_red_reg, C_CB_R) - scale(a_green_reg, C_CB_G);
    assign cr_acc = scale(a_red_reg, C_CR_R) + CHROMA_BIAS
                  - scale(a_green_reg, C_CR_G) - scale(a_blue_reg, C_CR_B);

    always_comb
    begin
        b_beat_next.luma        = to_byte(y_acc);
        b_beat_next.chroma_blue = to_byte(cb_acc);
        b_beat_next.chroma_red  = to_byte(cr_acc);
        b_beat_next.out_row     = a_row_reg;
        b_beat_next.out_column  = a_col_reg;
        b_beat_next.last_pixel  = a_last_reg;

        if (a_adv)
            b_valid_next = 1'b1;
        else if (ycc_out.ready)
            b_valid_next = 1'b0;
        else
            b_valid_next = b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
            b_beat_reg <= b_beat_next;
    end

    // Output drive
    assign ycc_out.valid       = b_valid_reg;
    assign ycc_out.luma        = b_beat_reg.luma;
    assign ycc_out.chroma_blue = b_beat_reg.chroma_blue;
    assign ycc_out.chroma_red  = b_beat_reg.chroma_red;
    assign ycc_out.out_row     = b_beat_reg.out_row;
    assign ycc_out.out_column  = b_beat_reg.out_column;
    assign ycc_out.last_pixel  = b_beat_reg.last_pixel;

    // Checks
    a_red_loads_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && emit) |=> a_valid_reg)
        else $error("completed pixel not captured in stage A");

    a_row_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_in_row_reg == '0) |-> (lane_reg == LANE_BLUE && col_reg == '0))
        else $error("lane or column counter out of step at row start");

    a_pos_in_stride: assert property (@(posedge clk) disable iff (!rst_n)
        byte_in_row_reg < STRIDE_MAX)
        else $error("byte position beyond widest row");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !a_valid_reg |-> pix_in.ready)
        else $error("input stalled with stage A empty");

    a_stage_a_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !b_valid_reg) |=> b_valid_reg)
        else $error("stage A did not move into a free output register");

endmodule

`default_nettype wire
